### sv/prlfu_pkg.sv
// Shared types, field widths and codes for the peer record LFU table.
package prlfu_pkg;

  // Default table shape
  localparam int SLOTS_DEF        = 32;
  localparam int KINDS_DEF        = 1;
  localparam int RECORD_BYTES_DEF = 8;

  // Field widths
  localparam int MODE_W   = 2;
  localparam int ADDR_W   = 48;
  localparam int KIND_W   = 3;
  localparam int LEN_W    = 4;
  localparam int IDX_W    = 5;
  localparam int REC_W    = 64;
  localparam int COUNT_W  = 32;
  localparam int STATUS_W = 3;

  // Stream widths
  localparam int IN_DATA_W  = 128;
  localparam int IN_USER_W  = 5;
  localparam int OUT_DATA_W = 112;
  localparam int OUT_USER_W = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_STORE = 2'd0,
    MODE_FETCH = 2'd1,
    MODE_ITER  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_KIND  = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  // One table entry as held in the slot memory
  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] count;
    logic [REC_W-1:0]   rec;
  } entry_t;

endpackage

### sv/prlfu_ram.sv
// Slot memory: one write port, one read port with registered read data.
module prlfu_ram #(
  parameter int SLOTS = prlfu_pkg::SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(SLOTS)-1:0] waddr,
  input  prlfu_pkg::entry_t        wdata,
  input  logic [$clog2(SLOTS)-1:0] raddr,
  output prlfu_pkg::entry_t        rdata
);
  import prlfu_pkg::*;

  entry_t mem [SLOTS];

  // Write on request, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/peer_record_lfu_table.sv
// Top level: LFU table of peer records keyed by a 48-bit device address.
// Flow: a rejected or ignored item goes from IDLE to DONE, an iterate through ITER,
//   store and fetch through SCAN and, on a store or a fetch hit, UPD before DONE.
// Throughput: one item in flight; store and fetch scan the slot memory through its
//   single read port, one slot per cycle.
// Reset: the per-slot used bits clear at once; no clearing pass.
module peer_record_lfu_table #(
  parameter int SLOTS        = prlfu_pkg::SLOTS_DEF,
  parameter int KINDS        = prlfu_pkg::KINDS_DEF,
  parameter int RECORD_BYTES = prlfu_pkg::RECORD_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // peer_address[47:0], byte_count[51:48], slot_index[56:52], record_data[120:57]
  input  logic [prlfu_pkg::IN_DATA_W-1:0]     in_tdata,
  // mode[1:0], record_kind[4:2]
  input  logic [prlfu_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // found_address[47:0], found_data[111:48]
  output logic [prlfu_pkg::OUT_DATA_W-1:0]    out_tdata,
  // status[2:0]
  output logic [prlfu_pkg::OUT_USER_W-1:0]    out_tuser
);
  import prlfu_pkg::*;

  localparam int SW   = $clog2(SLOTS);
  localparam int IDXW = (SW > IDX_W) ? SW : IDX_W;
  localparam logic [IDXW:0]      SLOTS_W  = (IDXW + 1)'(SLOTS);
  localparam logic [SW-1:0]      LAST_IDX = SW'(SLOTS - 1);
  localparam logic [KIND_W-1:0]  KINDS_W  = KIND_W'(KINDS);
  localparam logic [LEN_W-1:0]   BYTES_W  = LEN_W'(RECORD_BYTES);
  localparam logic [REC_W-1:0]   REC_MASK = {REC_W{1'b1}} >> (REC_W - 8 * RECORD_BYTES);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_ITER = 5'b00100,
    S_UPD  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  // Unpack the input transaction
  mode_t               in_mode;
  logic [ADDR_W-1:0]   in_addr;
  logic [KIND_W-1:0]   in_kind;
  logic [LEN_W-1:0]    in_len;
  logic [IDX_W-1:0]    in_idx;
  logic [REC_W-1:0]    in_data;
  logic [IDXW-1:0]     idx_ext;
  logic [SW-1:0]       idx_sw;
  logic                kind_ok;
  logic                len_ok;
  logic                idx_ok;

  assign in_mode = mode_t'(in_tuser[1:0]);
  assign in_kind = in_tuser[4:2];
  assign in_addr = in_tdata[47:0];
  assign in_len  = in_tdata[51:48];
  assign in_idx  = in_tdata[56:52];
  assign in_data = in_tdata[120:57];
  assign idx_ext = IDXW'(in_idx);
  assign idx_sw  = idx_ext[SW-1:0];
  assign kind_ok = (in_kind != '0) && (in_kind <= KINDS_W);
  assign len_ok  = (in_len <= BYTES_W);
  assign idx_ok  = ({1'b0, idx_ext} < SLOTS_W);

  // Control state
  state_t              state_r, state_nxt;
  logic [SLOTS-1:0]    used_r, used_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Item and scan payload
  mode_t               mode_r, mode_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [REC_W-1:0]    data_r, data_nxt;
  logic [SW-1:0]       cnt_r, cnt_nxt;
  logic [SW-1:0]       vidx_r, vidx_nxt;
  logic [COUNT_W-1:0]  vcnt_r, vcnt_nxt;
  logic [SW-1:0]       tgt_r, tgt_nxt;
  logic [COUNT_W-1:0]  tcnt_r, tcnt_nxt;
  logic [REC_W-1:0]    trec_r, trec_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]   res_faddr_r, res_faddr_nxt;
  logic [REC_W-1:0]    res_fdata_r, res_fdata_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]   out_faddr_r, out_faddr_nxt;
  logic [REC_W-1:0]    out_fdata_r, out_fdata_nxt;

  // Memory port
  logic                mem_we;
  entry_t              mem_wdata;
  logic [SW-1:0]       rd_addr;
  entry_t              cur;

  prlfu_ram #(
    .SLOTS (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (tgt_r),
    .wdata (mem_wdata),
    .raddr (rd_addr),
    .rdata (cur)
  );

  // Scan decisions on the slot just read
  logic                cur_used;
  logic                hit;
  logic                v_take;
  logic                last;

  assign cur_used = used_r[cnt_r];
  assign hit      = !cur_used || (cur.addr == addr_r);
  assign v_take   = (cnt_r == '0) || (cur.count < vcnt_r);
  assign last     = (cnt_r == LAST_IDX);

  // Write-back entry with saturating count
  always_comb begin
    mem_wdata.addr  = addr_r;
    mem_wdata.count = (tcnt_r == '1) ? tcnt_r : tcnt_r + 1'b1;
    mem_wdata.rec   = (mode_r == MODE_STORE) ? (data_r & REC_MASK) : trec_r;
  end

  // Next-state logic
  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    out_valid_nxt  = out_valid_r;
    mode_nxt       = mode_r;
    addr_nxt       = addr_r;
    data_nxt       = data_r;
    cnt_nxt        = cnt_r;
    vidx_nxt       = vidx_r;
    vcnt_nxt       = vcnt_r;
    tgt_nxt        = tgt_r;
    tcnt_nxt       = tcnt_r;
    trec_nxt       = trec_r;
    res_status_nxt = res_status_r;
    res_faddr_nxt  = res_faddr_r;
    res_fdata_nxt  = res_fdata_r;
    out_status_nxt = out_status_r;
    out_faddr_nxt  = out_faddr_r;
    out_fdata_nxt  = out_fdata_r;
    mem_we         = 1'b0;
    rd_addr        = '0;

    // Drop the output once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        rd_addr = (in_mode == MODE_ITER) ? idx_sw : '0;
        if (in_tvalid) begin
          mode_nxt       = in_mode;
          addr_nxt       = in_addr;
          data_nxt       = in_data;
          cnt_nxt        = '0;
          res_status_nxt = ST_OK;
          res_faddr_nxt  = '0;
          res_fdata_nxt  = '0;
          state_nxt      = S_DONE;
          if (in_mode == MODE_NONE) begin
            res_status_nxt = ST_OK;
          end else if (!kind_ok) begin
            res_status_nxt = ST_BAD_KIND;
          end else if (in_mode == MODE_ITER) begin
            if (!idx_ok || !used_r[idx_sw]) begin
              res_status_nxt = ST_EMPTY;
            end else if (!len_ok) begin
              res_status_nxt = ST_TOO_LONG;
            end else begin
              state_nxt = S_ITER;
            end
          end else if (!len_ok) begin
            res_status_nxt = ST_TOO_LONG;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Prefetch the next slot while judging this one
        rd_addr = cnt_r + 1'b1;
        if (hit) begin
          tgt_nxt  = cnt_r;
          tcnt_nxt = cur_used ? cur.count : '0;
          trec_nxt = cur.rec;
          if (mode_r == MODE_STORE || cur_used) begin
            state_nxt = S_UPD;
          end else begin
            res_status_nxt = ST_NOT_FOUND;
            state_nxt      = S_DONE;
          end
        end else begin
          if (v_take) begin
            vidx_nxt = cnt_r;
            vcnt_nxt = cur.count;
          end
          if (last) begin
            // Table full with no match: evict for store, miss for fetch
            tgt_nxt  = v_take ? cnt_r : vidx_r;
            tcnt_nxt = v_take ? cur.count : vcnt_r;
            if (mode_r == MODE_STORE) begin
              state_nxt = S_UPD;
            end else begin
              res_status_nxt = ST_NOT_FOUND;
              state_nxt      = S_DONE;
            end
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end

      S_ITER: begin
        res_faddr_nxt = cur.addr;
        res_fdata_nxt = cur.rec;
        state_nxt     = S_DONE;
      end

      S_UPD: begin
        // Write back the entry; the following read comes no earlier than DONE
        mem_we          = 1'b1;
        used_nxt[tgt_r] = 1'b1;
        res_fdata_nxt   = (mode_r == MODE_FETCH) ? trec_r : '0;
        state_nxt       = S_DONE;
      end

      S_DONE: begin
        // Hand the result over once the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_faddr_nxt  = res_faddr_r;
          out_fdata_nxt  = res_fdata_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    addr_r       <= addr_nxt;
    data_r       <= data_nxt;
    cnt_r        <= cnt_nxt;
    vidx_r       <= vidx_nxt;
    vcnt_r       <= vcnt_nxt;
    tgt_r        <= tgt_nxt;
    tcnt_r       <= tcnt_nxt;
    trec_r       <= trec_nxt;
    res_status_r <= res_status_nxt;
    res_faddr_r  <= res_faddr_nxt;
    res_fdata_r  <= res_fdata_nxt;
    out_status_r <= out_status_nxt;
    out_faddr_r  <= out_faddr_nxt;
    out_fdata_r  <= out_fdata_nxt;
  end

  // Drive the ports
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_fdata_r, out_faddr_r};
  assign out_tuser  = out_status_r;

  // A written slot is marked valid right after its write-back
  a_upd_marks_used: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |=> used_r[$past(tgt_r)])
    else $error("slot not marked valid after write-back");

  // A fetch only updates a slot that was already in use
  a_fetch_hit_used: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && mode_r == MODE_FETCH) |-> (tcnt_r != '0))
    else $error("fetch updated an empty slot");

  // A finished result's status lands in the output register unchanged
  a_result_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (!out_valid_r || out_tready))
      |=> (out_tvalid && out_tuser == $past(res_status_r)))
    else $error("result not handed to the output register");

endmodule

### tb/sv/tb.sv
// Self-checking stream testbench for the peer record LFU table.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import prlfu_pkg::*;

  localparam int N_SLOTS        = SLOTS_DEF;
  localparam int N_KINDS        = KINDS_DEF;
  localparam int N_REC_BYTES    = RECORD_BYTES_DEF;
  localparam logic [REC_W-1:0] REC_MASK =
    (N_REC_BYTES >= 8) ? {REC_W{1'b1}} : ((64'd1 << (8 * N_REC_BYTES)) - 64'd1);
  localparam int ERR_SHOW       = 10;
  localparam int STALL_LIMIT    = 4000;
  localparam int SETTLE_CYCLES  = N_SLOTS + 8;
  localparam logic [ADDR_W-1:0] ADDR_ONES = {ADDR_W{1'b1}};
  localparam logic [REC_W-1:0]  REC_ONES  = {REC_W{1'b1}};

  typedef struct {
    status_t             status;
    logic [ADDR_W-1:0]   addr;
    logic [REC_W-1:0]    data;
  } lfu_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  logic [IN_USER_W-1:0]   in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic [OUT_USER_W-1:0]  out_tuser;

  // Shadow copy of the table
  bit [ADDR_W-1:0]  peer_addr [N_SLOTS];
  bit [COUNT_W-1:0] ref_cnt   [N_SLOTS];
  bit               kind_bit  [N_SLOTS];
  bit [REC_W-1:0]   peer_rec  [N_SLOTS];

  lfu_result_t pending_results [$];

  int  n_items, n_results, n_errors, n_hits, n_evictions, n_rejects;
  int  stall_left, idle_cycles;
  bit  tx_idle_en = 1'b1;
  bit  rx_stall_en = 1'b1;

  peer_record_lfu_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  // Saturating reference count increment
  function automatic void bump_count(input int s);
    if (ref_cnt[s] != {COUNT_W{1'b1}}) ref_cnt[s]++;
  endfunction

  // First empty or matching slot, or N_SLOTS; victim is the first least-used slot
  function automatic int find_slot(input logic [ADDR_W-1:0] addr, output int victim);
    int i;
    victim = 0;
    for (i = 0; i < N_SLOTS; i++) begin
      if (ref_cnt[i] == 0 || peer_addr[i] == addr) break;
      if (ref_cnt[i] < ref_cnt[victim]) victim = i;
    end
    return i;
  endfunction

  // Apply one request to the shadow table and return the response it gives
  function automatic lfu_result_t predict_lfu(input mode_t op, input logic [ADDR_W-1:0] addr,
                                              input logic [KIND_W-1:0] kind,
                                              input logic [LEN_W-1:0] len,
                                              input logic [IDX_W-1:0] idx,
                                              input logic [REC_W-1:0] data);
    lfu_result_t r;
    int slot;
    int victim;
    r.status = ST_OK;
    r.addr   = '0;
    r.data   = '0;
    if (op == MODE_NONE) begin
      // unused mode: no effect
    end else if (kind < 1 || kind > N_KINDS) begin
      r.status = ST_BAD_KIND;
    end else if (op == MODE_ITER) begin
      if (idx >= N_SLOTS || ref_cnt[idx] == 0) begin
        r.status = ST_EMPTY;
      end else if (len > N_REC_BYTES) begin
        r.status = ST_TOO_LONG;
      end else begin
        r.addr = peer_addr[idx];
        r.data = peer_rec[idx];
      end
    end else if (len > N_REC_BYTES) begin
      r.status = ST_TOO_LONG;
    end else if (op == MODE_STORE) begin
      slot = find_slot(addr, victim);
      if (slot >= N_SLOTS) begin
        slot = victim;
        n_evictions++;
      end
      peer_addr[slot] = addr;
      bump_count(slot);
      kind_bit[slot]  = 1'b1;
      peer_rec[slot]  = data & REC_MASK;
    end else begin
      slot = find_slot(addr, victim);
      if (slot < N_SLOTS && ref_cnt[slot] != 0 && kind_bit[slot]) begin
        r.data = peer_rec[slot];
        bump_count(slot);
        n_hits++;
      end else begin
        r.status = ST_NOT_FOUND;
      end
    end
    if (r.status == ST_BAD_KIND || r.status == ST_TOO_LONG) n_rejects++;
    return r;
  endfunction

  // Present one request, hold it until accepted, then record its expected response
  task automatic send_request(input mode_t op, input logic [ADDR_W-1:0] addr,
                              input logic [KIND_W-1:0] kind, input logic [LEN_W-1:0] len,
                              input logic [IDX_W-1:0] idx, input logic [REC_W-1:0] data);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, data, idx, len, addr};
    in_tuser  <= {kind, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_lfu(op, addr, kind, len, idx, data));
    n_items++;
  endtask

  // Stop sending and wait until every response is back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {16'($urandom_range(0, 16'hFFFF)), 32'($urandom)};
  endfunction

  function automatic logic [REC_W-1:0] rand_rec();
    return {32'($urandom), 32'($urandom)};
  endfunction

  // Response side: compare each transaction, then draw a stall before the next
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          n_errors++;
          if (n_errors <= ERR_SHOW)
            $display("response %0d arrived with none outstanding: status %0d addr %h data %h",
                     n_results, out_tuser, out_tdata[ADDR_W-1:0], out_tdata[OUT_DATA_W-1:ADDR_W]);
        end else begin
          lfu_result_t want;
          want = pending_results.pop_front();
          if (out_tuser !== want.status || out_tdata[ADDR_W-1:0] !== want.addr ||
              out_tdata[OUT_DATA_W-1:ADDR_W] !== want.data) begin
            n_errors++;
            if (n_errors <= ERR_SHOW)
              $display("response %0d: expected status %0d addr %h data %h, got status %0d addr %h data %h",
                       n_results, want.status, want.addr, want.data, out_tuser,
                       out_tdata[ADDR_W-1:0], out_tdata[OUT_DATA_W-1:ADDR_W]);
          end
        end
        stall_left = rx_stall_en ? $urandom_range(0, 4) : 0;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles, %0d responses outstanding",
                 idle_cycles, pending_results.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Rejections, empty-table misses, boundary values, overwrite and the unused mode
  task automatic test_directed();
    logic [ADDR_W-1:0] addr_a;
    addr_a = 48'hA5A5_5A5A_0F0F;
    send_request(MODE_FETCH, addr_a, 3'd1, 4'd8, 5'd0, '0);
    send_request(MODE_ITER, '0, 3'd1, 4'd0, 5'd0, '0);
    send_request(MODE_ITER, '0, 3'd0, 4'd0, 5'd31, '0);
    send_request(MODE_STORE, addr_a, 3'd0, 4'd8, 5'd0, rand_rec());
    send_request(MODE_STORE, addr_a, 3'd7, 4'd8, 5'd0, rand_rec());
    send_request(MODE_STORE, addr_a, 3'd1, 4'd9, 5'd0, rand_rec());
    send_request(MODE_STORE, addr_a, 3'd1, 4'd15, 5'd0, rand_rec());
    send_request(MODE_STORE, '0, 3'd1, 4'd0, 5'd0, '0);
    send_request(MODE_STORE, ADDR_ONES, 3'd1, 4'd8, 5'd31, REC_ONES);
    send_request(MODE_STORE, addr_a, 3'd1, 4'd4, 5'd0, 64'h0123_4567_89AB_CDEF);
    send_request(MODE_FETCH, ADDR_ONES, 3'd1, 4'd8, 5'd0, '0);
    send_request(MODE_FETCH, '0, 3'd1, 4'd0, 5'd0, '0);
    send_request(MODE_FETCH, addr_a, 3'd1, 4'd15, 5'd0, '0);
    send_request(MODE_FETCH, addr_a, 3'd3, 4'd8, 5'd0, '0);
    send_request(MODE_FETCH, 48'h0000_0000_0001, 3'd1, 4'd8, 5'd0, '0);
    send_request(MODE_STORE, addr_a, 3'd1, 4'd8, 5'd0, 64'hFEDC_BA98_7654_3210);
    send_request(MODE_ITER, '0, 3'd1, 4'd8, 5'd2, '0);
    send_request(MODE_ITER, '0, 3'd1, 4'd9, 5'd1, '0);
    send_request(MODE_ITER, '0, 3'd1, 4'd8, 5'd31, '0);
    send_request(MODE_NONE, ADDR_ONES, 3'd7, 4'd15, 5'd31, REC_ONES);
    send_request(MODE_NONE, addr_a, 3'd0, 4'd0, 5'd1, rand_rec());
    send_request(MODE_ITER, '0, 3'd2, 4'd0, 5'd0, '0);
  endtask

  // Fill the table past capacity so stores evict, then walk every slot
  task automatic test_table_walk();
    logic [ADDR_W-1:0] fresh [40];
    int i;
    tx_idle_en  = 1'b0;
    rx_stall_en = 1'b0;
    for (i = 0; i < 40; i++) begin
      fresh[i] = rand_addr();
      send_request(MODE_STORE, fresh[i], 3'd1, 4'($urandom_range(0, 8)), 5'd0, rand_rec());
      // raise some counts unevenly so the least-used choice varies
      if (i % 3 == 0) send_request(MODE_FETCH, fresh[i], 3'd1, 4'd8, 5'd0, '0);
    end
    tx_idle_en  = 1'b1;
    rx_stall_en = 1'b1;
    for (i = 0; i < N_SLOTS; i++)
      send_request(MODE_ITER, '0, 3'd1, 4'($urandom_range(0, 8)), 5'(i), '0);
    for (i = 0; i < 10; i++)
      send_request(MODE_FETCH, fresh[i], 3'd1, 4'd8, 5'd0, '0);
  endtask

  // Mostly well-formed traffic over a reused address set, some malformed requests
  task automatic test_random_mix(input int count);
    logic [ADDR_W-1:0] addr_pool [48];
    logic [ADDR_W-1:0] addr;
    logic [KIND_W-1:0] kind;
    logic [LEN_W-1:0]  len;
    mode_t             op;
    int                i, pick;
    addr_pool[0] = '0;
    addr_pool[1] = ADDR_ONES;
    for (i = 2; i < 48; i++) addr_pool[i] = rand_addr();
    for (i = 0; i < count; i++) begin
      // change the idling pattern every hundred requests
      if (i % 100 == 0) begin
        tx_idle_en  = $urandom_range(0, 2) != 0;
        rx_stall_en = $urandom_range(0, 2) != 0;
      end
      if (i == count / 2) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 38) op = MODE_STORE;
      else if (pick < 75) op = MODE_FETCH;
      else if (pick < 94) op = MODE_ITER;
      else op = MODE_NONE;
      addr = ($urandom_range(0, 99) < 82) ? addr_pool[$urandom_range(0, 47)] : rand_addr();
      kind = ($urandom_range(0, 99) < 88) ? 3'd1 : 3'($urandom_range(0, 7));
      len  = ($urandom_range(0, 99) < 88) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15));
      send_request(op, addr, kind, len, 5'($urandom_range(0, 31)), rand_rec());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_walk();
    test_random_mix(530);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d requests (stores, fetches, slot reads, rejects and the unused mode);",
             n_items);
    $display("saw %0d fetch hits, %0d evictions, %0d rejections, %0d mismatches.",
             n_hits, n_evictions, n_rejects, n_errors);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
